// ===== hdl/block_average_downscaler_top_assert.svh =====
// Assertion macros shared by the downscaler RTL.
`ifndef BLOCK_AVERAGE_DOWNSCALER_TOP_ASSERT_SVH
`define BLOCK_AVERAGE_DOWNSCALER_TOP_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define BAD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define BAD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bad_pkg.sv =====
// Shared types and constants of the block average downscaler.
package bad_pkg;

    localparam int PIX_W     = 8;
    localparam int RADIUS_W  = 6;
    localparam int CFG_DIM_W = 11;
    localparam int DIM_W     = 13;
    localparam int SIDE_W    = 8;
    localparam int AREA_W    = 16;
    localparam int SUM_W     = 24;
    localparam int DIV_STEPS = 24;
    localparam int DCNT_W    = 5;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_RADIUS = 63;

    localparam logic [RADIUS_W-1:0]  RST_RADIUS = 6'd0;
    localparam logic [CFG_DIM_W-1:0] RST_WIDTH  = 11'd640;
    localparam logic [CFG_DIM_W-1:0] RST_HEIGHT = 11'd480;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef enum logic [5:0] {
        ST_LOAD  = 6'b000001,
        ST_SETUP = 6'b000010,
        ST_IDLE  = 6'b000100,
        ST_ACC   = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    typedef struct packed {
        logic               we;
        logic               first;
        logic               start;
        logic               step;
        logic [AREA_W-1:0]  area;
    } t_lane_ctl;

endpackage

// ===== hdl/bad_pix_if.sv =====
// Pixel input channel.
interface bad_pix_if;
    logic                      valid;
    logic                      ready;
    logic [bad_pkg::PIX_W-1:0] red_in;
    logic [bad_pkg::PIX_W-1:0] green_in;
    logic [bad_pkg::PIX_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

// ===== hdl/bad_res_if.sv =====
// Block average result channel.
interface bad_res_if;
    logic                      valid;
    logic                      ready;
    logic [bad_pkg::PIX_W-1:0] red_out;
    logic [bad_pkg::PIX_W-1:0] green_out;
    logic [bad_pkg::PIX_W-1:0] blue_out;
    logic                      row_end;
    logic                      frame_end;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output row_end, output frame_end, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input row_end, input frame_end, output ready);
endinterface

// ===== hdl/bad_ram.sv =====
// Generic single write port RAM with registered read.
module bad_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/bad_lane.sv =====
// One color lane: column sum store, accumulate and restoring divider.
module bad_lane #(
    parameter int DEPTH = bad_pkg::DEF_MAX_WIDTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      i_clk,
    input  bad_pkg::t_lane_ctl        i_ctl,
    input  logic [AW-1:0]             i_addr,
    input  logic [bad_pkg::PIX_W-1:0] i_pix,
    output logic [bad_pkg::PIX_W-1:0] o_quot
);
    logic [bad_pkg::SUM_W-1:0]  rdata;
    logic [bad_pkg::SUM_W-1:0]  sum;
    logic [bad_pkg::SUM_W-1:0]  r_quo;
    logic [bad_pkg::AREA_W-1:0] r_rem;
    logic [bad_pkg::AREA_W-1:0] r_area;
    logic [bad_pkg::AREA_W:0]   trial;

    // Overwrite on the first pixel of a block, otherwise add
    assign sum = i_ctl.first ? bad_pkg::SUM_W'(i_pix) : rdata + bad_pkg::SUM_W'(i_pix);

    bad_ram #(.WIDTH(bad_pkg::SUM_W), .DEPTH(DEPTH)) u_sums (
        .i_clk   (i_clk),
        .i_we    (i_ctl.we),
        .i_waddr (i_addr),
        .i_wdata (sum),
        .i_raddr (i_addr),
        .o_rdata (rdata)
    );

    // Shift in one dividend bit per step
    assign trial = {r_rem, r_quo[bad_pkg::SUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo  <= sum;
            r_rem  <= '0;
            r_area <= i_ctl.area;
        end else if (i_ctl.step) begin
            if (trial >= {1'b0, r_area}) begin
                r_rem <= bad_pkg::AREA_W'(trial - {1'b0, r_area});
                r_quo <= {r_quo[bad_pkg::SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[bad_pkg::AREA_W-1:0];
                r_quo <= {r_quo[bad_pkg::SUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_quot = r_quo[bad_pkg::PIX_W-1:0];
endmodule

// ===== hdl/block_average_downscaler_top.sv =====
// Top level of the block average downscaler: control, counters, lanes and output merge.
//
//  channel  | dir | transfer
//  ---------+-----+---------------------------------------------
//  i_pix    | in  | one RGB raster pixel per transaction
//  o_res    | out | one block average with row/frame end marks
//  APB      | in  | radius 0x0, width 0x4, height 0x8
//
// A pixel runs a sum RAM read, then an add and write back; a pixel
// that closes a block then runs the bit-serial divider and waits to load the output register.
// After reset and after every write to a known register, a setup pass
// computes the block counts before pixels are taken.
// A pending result waits in the output register while the next pixel runs.
`include "block_average_downscaler_top_assert.svh"
module block_average_downscaler_top #(
    parameter int MAX_WIDTH  = bad_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bad_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = bad_pkg::DEF_MAX_RADIUS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    bad_pix_if.sink                    i_pix,
    bad_res_if.source                  o_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bad_pkg::APB_AW-1:0] paddr,
    input  logic [bad_pkg::APB_DW-1:0] pwdata,
    output logic [bad_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DW  = bad_pkg::DIM_W;
    localparam int SW  = bad_pkg::SIDE_W;
    localparam int PW  = bad_pkg::PIX_W;

    bad_pkg::t_state r_state;

    logic [bad_pkg::RADIUS_W-1:0]  r_radius;
    logic [bad_pkg::CFG_DIM_W-1:0] r_width;
    logic [bad_pkg::CFG_DIM_W-1:0] r_height;

    logic [SW-1:0] r_side, r_lastw, r_lasth;
    logic [DW-1:0] r_weff, r_heff, r_wrem, r_hrem, r_cw, r_ch;
    logic          r_valid;
    logic [DW-1:0] r_x, r_y, r_bc, r_br;
    logic [SW-1:0] r_cib, r_rib;
    logic [bad_pkg::DCNT_W-1:0] r_dcnt;
    logic [PW-1:0] r_red, r_green, r_blue;
    logic          r_re, r_fe;

    logic          r_ov;
    logic [PW-1:0] r_ored, r_ogreen, r_oblue;
    logic          r_ore, r_ofe;

    logic          cfg_wr, cfg_hit, accept;
    logic [SW-1:0] dsat, side_calc;
    logic [DW-1:0] w_eff, h_eff;
    logic          last_bc, last_br, x_last, y_last, cib_end, rib_end;
    logic          last_col, last_row, emit, first;
    logic [SW-1:0] bw, bh;
    logic [bad_pkg::AREA_W-1:0] area;
    logic          out_load;
    bad_pkg::t_lane_ctl ctl;
    logic [PW-1:0] q_red, q_green, q_blue;

    // Register port; only a write to a known register restarts the frame
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_hit = cfg_wr && (paddr[3:2] inside {bad_pkg::REG_RADIUS, bad_pkg::REG_WIDTH,
                                                   bad_pkg::REG_HEIGHT});
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= bad_pkg::RST_RADIUS;
            r_width  <= bad_pkg::RST_WIDTH;
            r_height <= bad_pkg::RST_HEIGHT;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                bad_pkg::REG_RADIUS: r_radius <= pwdata[bad_pkg::RADIUS_W-1:0];
                bad_pkg::REG_WIDTH:  r_width  <= pwdata[bad_pkg::CFG_DIM_W-1:0];
                bad_pkg::REG_HEIGHT: r_height <= pwdata[bad_pkg::CFG_DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            bad_pkg::REG_RADIUS: prdata = bad_pkg::APB_DW'(r_radius);
            bad_pkg::REG_WIDTH:  prdata = bad_pkg::APB_DW'(r_width);
            bad_pkg::REG_HEIGHT: prdata = bad_pkg::APB_DW'(r_height);
            default:             prdata = '0;
        endcase
    end

    // Saturate radius and dimensions
    assign dsat = (SW'(r_radius) > SW'(MAX_RADIUS)) ? SW'(MAX_RADIUS) : SW'(r_radius);
    assign side_calc = {dsat[SW-2:0], 1'b1};
    assign w_eff = (r_width == '0) ? DW'(1) :
                   ((DW'(r_width) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(r_width));
    assign h_eff = (r_height == '0) ? DW'(1) :
                   ((DW'(r_height) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(r_height));

    // Position decode for the pixel in flight
    assign last_bc  = (r_bc == r_cw - DW'(1));
    assign last_br  = (r_br == r_ch - DW'(1));
    assign x_last   = (r_x == r_weff - DW'(1));
    assign y_last   = (r_y == r_heff - DW'(1));
    assign cib_end  = (r_cib == r_side - SW'(1));
    assign rib_end  = (r_rib == r_side - SW'(1));
    assign last_col = x_last || (!last_bc && cib_end);
    assign last_row = y_last || (!last_br && rib_end);
    assign emit     = r_valid && last_col && last_row;
    assign first    = (r_cib == '0) && (r_rib == '0);
    assign bw       = last_bc ? r_lastw : r_side;
    assign bh       = last_br ? r_lasth : r_side;
    assign area     = bw * bh;

    assign accept      = i_pix.valid && i_pix.ready;
    assign i_pix.ready = (r_state == bad_pkg::ST_IDLE);
    assign out_load    = (r_state == bad_pkg::ST_DONE) && (!r_ov || o_res.ready);

    // Sequencer and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bad_pkg::ST_LOAD;
        end else if (cfg_hit) begin
            r_state <= bad_pkg::ST_LOAD;
        end else begin
            case (r_state)
                bad_pkg::ST_LOAD: begin
                    r_state <= bad_pkg::ST_SETUP;
                end
                bad_pkg::ST_SETUP: begin
                    if (r_wrem < DW'(r_side) && r_hrem < DW'(r_side)) begin
                        r_state <= bad_pkg::ST_IDLE;
                    end
                end
                bad_pkg::ST_IDLE: begin
                    if (accept) begin
                        r_state <= bad_pkg::ST_ACC;
                    end
                end
                bad_pkg::ST_ACC: begin
                    r_state <= emit ? bad_pkg::ST_DIV : bad_pkg::ST_IDLE;
                end
                bad_pkg::ST_DIV: begin
                    if (r_dcnt == bad_pkg::DCNT_W'(bad_pkg::DIV_STEPS - 1)) begin
                        r_state <= bad_pkg::ST_DONE;
                    end
                end
                bad_pkg::ST_DONE: begin
                    if (out_load) begin
                        r_state <= bad_pkg::ST_IDLE;
                    end
                end
                default: r_state <= bad_pkg::ST_LOAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit || r_state == bad_pkg::ST_LOAD) begin
            r_x   <= '0;
            r_y   <= '0;
            r_bc  <= '0;
            r_br  <= '0;
            r_cib <= '0;
            r_rib <= '0;
        end else if (r_state == bad_pkg::ST_ACC) begin
            if (x_last) begin
                r_x   <= '0;
                r_bc  <= '0;
                r_cib <= '0;
                if (y_last) begin
                    r_y   <= '0;
                    r_br  <= '0;
                    r_rib <= '0;
                end else begin
                    r_y <= r_y + DW'(1);
                    if (rib_end && !last_br) begin
                        r_br  <= r_br + DW'(1);
                        r_rib <= '0;
                    end else begin
                        r_rib <= r_rib + SW'(1);
                    end
                end
            end else begin
                r_x <= r_x + DW'(1);
                if (cib_end && !last_bc) begin
                    r_bc  <= r_bc + DW'(1);
                    r_cib <= '0;
                end else begin
                    r_cib <= r_cib + SW'(1);
                end
            end
        end
    end

    // Count blocks per row and column by repeated subtraction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (r_state == bad_pkg::ST_LOAD) begin
            r_valid <= 1'b0;
            r_side  <= side_calc;
            r_weff  <= w_eff;
            r_heff  <= h_eff;
            r_wrem  <= w_eff;
            r_hrem  <= h_eff;
            r_cw    <= '0;
            r_ch    <= '0;
        end else if (r_state == bad_pkg::ST_SETUP) begin
            if (r_wrem >= DW'(r_side)) begin
                r_wrem <= r_wrem - DW'(r_side);
                r_cw   <= r_cw + DW'(1);
            end
            if (r_hrem >= DW'(r_side)) begin
                r_hrem <= r_hrem - DW'(r_side);
                r_ch   <= r_ch + DW'(1);
            end
            r_lastw <= r_side + r_wrem[SW-1:0];
            r_lasth <= r_side + r_hrem[SW-1:0];
            r_valid <= (r_cw != '0) && (r_ch != '0);
        end
    end

    // Hold the pixel and the block marks
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_red   <= i_pix.red_in;
            r_green <= i_pix.green_in;
            r_blue  <= i_pix.blue_in;
        end
        if (r_state == bad_pkg::ST_ACC) begin
            r_re   <= last_bc;
            r_fe   <= last_bc && last_br;
            r_dcnt <= '0;
        end else if (r_state == bad_pkg::ST_DIV) begin
            r_dcnt <= r_dcnt + bad_pkg::DCNT_W'(1);
        end
    end

    // Lanes
    assign ctl.we    = (r_state == bad_pkg::ST_ACC) && r_valid;
    assign ctl.first = first;
    assign ctl.start = (r_state == bad_pkg::ST_ACC) && emit;
    assign ctl.step  = (r_state == bad_pkg::ST_DIV);
    assign ctl.area  = area;

    bad_lane #(.DEPTH(MAX_WIDTH)) u_red (
        .i_clk(i_clk), .i_ctl(ctl), .i_addr(r_bc[AW-1:0]), .i_pix(r_red), .o_quot(q_red)
    );
    bad_lane #(.DEPTH(MAX_WIDTH)) u_green (
        .i_clk(i_clk), .i_ctl(ctl), .i_addr(r_bc[AW-1:0]), .i_pix(r_green), .o_quot(q_green)
    );
    bad_lane #(.DEPTH(MAX_WIDTH)) u_blue (
        .i_clk(i_clk), .i_ctl(ctl), .i_addr(r_bc[AW-1:0]), .i_pix(r_blue), .o_quot(q_blue)
    );

    // Merge lane results into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_ored   <= q_red;
            r_ogreen <= q_green;
            r_oblue  <= q_blue;
            r_ore    <= r_re;
            r_ofe    <= r_fe;
        end
    end

    assign o_res.valid     = r_ov;
    assign o_res.red_out   = r_ored;
    assign o_res.green_out = r_ogreen;
    assign o_res.blue_out  = r_oblue;
    assign o_res.row_end   = r_ore;
    assign o_res.frame_end = r_ofe;

    `BAD_ASSERT_NEXT(a_accept_to_acc, accept && !cfg_wr, r_state == bad_pkg::ST_ACC, "accepted pixel did not enter accumulate")
    `BAD_ASSERT_NOW(a_frame_has_row, r_ov && r_ofe, r_ore, "frame end without row end")
    `BAD_ASSERT_NOW(a_result_from_done, $rose(r_ov), $past(r_state == bad_pkg::ST_DONE), "result raised outside done")
endmodule
